// File: design/hcfc_pkg.sv
`default_nettype none

package hcfc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    // CRC-8, poly 0x07, MSB first
    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [1:0] {
        VERD_REJECT = 2'd0,
        VERD_DATA   = 2'd1,
        VERD_ACK    = 2'd2,
        VERD_OTHER  = 2'd3
    } verdict_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // ASCII hex char to value; non-hex chars give wrapped garbage
    function automatic logic [7:0] hex_nibble_in(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] s;
        u = (c >= CH_LOW_A && c <= CH_LOW_Z) ? (c - 8'h20) : c;
        s = u - CH_ZERO;
        if (s > 8'd9)
        begin
            s = s - 8'd7;
        end
        return s;
    endfunction

    function automatic logic [7:0] hex_char_out(input logic [3:0] nib);
        return (nib > 4'd9) ? (8'h37 + {4'h0, nib}) : (CH_ZERO + {4'h0, nib});
    endfunction

    function automatic logic [7:0] hex_pair_in(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        h = hex_nibble_in(hi);
        return {h[3:0], 4'h0} + hex_nibble_in(lo);
    endfunction

endpackage

`default_nettype wire

// File: design/hex_crc8_frame_checker.sv
`default_nettype none

// ASCII frame checker with CRC-8 (poly 0x07, init 0). Frame bytes enter on the
// slave stream, one per transaction, tlast on the final byte. A frame passes when
// its length is 5..MaxFrame-1, it ends in CR LF, and the two hex characters before
// CR match the CRC-8 of all earlier bytes. For each frame one verdict transaction
// goes out (tuser = 0), id parsed from bytes 1 and 2 (zero if rejected); a good
// 'D' or 'B' frame is followed by the seven ACK bytes (tuser = 1): 'A', id hex,
// CRC hex, CR, LF; tlast marks the last transaction of a frame's results.
// Rate: one byte per cycle unless stalled. Each byte passes the input register;
// the state update and the frame check sit between that register and the result
// register. A frame-end byte waits in the input register until the result sequencer
// has sent the previous frame's results, so a frame-end costs 1 output transaction
// for a rejected or non-data frame and 8 for a good data frame; bytes of the next
// frame keep flowing while the ACK goes out.
module hex_crc8_frame_checker #(
    parameter int MaxFrame = hcfc_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // frame_end

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [1:0] verdict, [9:2] trans_id,
                                             // [17:10] ack_byte, [23:18] zero
    output logic             m_axis_tuser,   // is_ack_byte
    output logic             m_axis_tlast    // run_last
);
    import hcfc_pkg::*;

    localparam int CntW = $clog2(MaxFrame + 1);
    localparam logic [7:0] AckSeed = crc8_update(8'h00, CH_A);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // frame state
    logic [7:0]      crc_reg;
    logic [7:0]      tail_reg [4];
    logic [CntW-1:0] cnt_reg;
    logic [7:0]      type_reg;
    logic [7:0]      id0_reg;
    logic [7:0]      id1_reg;

    // result sequencer
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_idx_reg, out_idx_next;
    verdict_t   res_verdict_reg, res_verdict_next;
    logic [7:0] res_id_reg, res_id_next;
    logic [7:0] ack_crc_reg;

    logic            s_take, advance, fire, load, take, out_last, seq_free;
    logic [7:0]      crc_upd;
    logic [7:0]      tail_new [4];
    logic [CntW-1:0] cnt_new;
    logic [7:0]      type_new, id0_new, id1_new;
    logic [7:0]      rx_crc, frame_id;
    logic            frame_ok;
    verdict_t        frame_verdict;
    logic [7:0]      out_byte;

    // ---------------- per-byte state update ----------------
    always_comb
    begin
        crc_upd     = (cnt_reg >= CntW'(4)) ? crc8_update(crc_reg, tail_reg[0]) : crc_reg;
        tail_new[0] = tail_reg[1];
        tail_new[1] = tail_reg[2];
        tail_new[2] = tail_reg[3];
        tail_new[3] = in_byte_reg;
        type_new    = (cnt_reg == CntW'(0)) ? in_byte_reg : type_reg;
        id0_new     = (cnt_reg == CntW'(1)) ? in_byte_reg : id0_reg;
        id1_new     = (cnt_reg == CntW'(2)) ? in_byte_reg : id1_reg;
        cnt_new     = (cnt_reg < CntW'(MaxFrame)) ? (cnt_reg + CntW'(1)) : cnt_reg;

        rx_crc   = hex_pair_in(tail_new[0], tail_new[1]);
        frame_ok = (cnt_new >= CntW'(5)) && (cnt_new < CntW'(MaxFrame)) &&
                   (tail_new[2] == CH_CR) && (tail_new[3] == CH_LF) &&
                   (rx_crc == crc_upd);
        frame_id = frame_ok ? hex_pair_in(id0_new, id1_new) : 8'h00;

        if (!frame_ok)
        begin
            frame_verdict = VERD_REJECT;
        end
        else if (type_new == CH_D || type_new == CH_B)
        begin
            frame_verdict = VERD_DATA;
        end
        else if (type_new == CH_A)
        begin
            frame_verdict = VERD_ACK;
        end
        else
        begin
            frame_verdict = VERD_OTHER;
        end
    end

    // ---------------- handshake and sequencing ----------------
    always_comb
    begin
        take     = out_valid_reg && m_axis_tready;
        out_last = ((out_idx_reg == 3'd0) && (res_verdict_reg != VERD_DATA)) ||
                   (out_idx_reg == 3'd7);
        seq_free = !out_valid_reg || (take && out_last);

        // only a frame-end byte needs room in the sequencer
        advance       = !in_end_reg || seq_free;
        fire          = in_valid_reg && advance;
        load          = fire && in_end_reg;
        s_axis_tready = !in_valid_reg || advance;
        s_take        = s_axis_tvalid && s_axis_tready;

        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next   = out_valid_reg;
        out_idx_next     = out_idx_reg;
        res_verdict_next = res_verdict_reg;
        res_id_next      = res_id_reg;
        if (load)
        begin
            out_valid_next   = 1'b1;
            out_idx_next     = 3'd0;
            res_verdict_next = frame_verdict;
            res_id_next      = frame_id;
        end
        else if (take)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_end_reg      <= 1'b0;
            crc_reg         <= 8'h00;
            cnt_reg         <= '0;
            type_reg        <= 8'h00;
            id0_reg         <= 8'h00;
            id1_reg         <= 8'h00;
            for (int i = 0; i < 4; i++)
            begin
                tail_reg[i] <= 8'h00;
            end
            out_valid_reg   <= 1'b0;
            out_idx_reg     <= 3'd0;
            res_verdict_reg <= VERD_REJECT;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            out_idx_reg     <= out_idx_next;
            res_verdict_reg <= res_verdict_next;
            if (s_take)
            begin
                in_end_reg <= s_axis_tlast;
            end
            if (fire)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    tail_reg[i] <= tail_new[i];
                end
                type_reg <= type_new;
                id0_reg  <= id0_new;
                id1_reg  <= id1_new;
                // crc and length restart after the frame end
                crc_reg  <= in_end_reg ? 8'h00 : crc_upd;
                cnt_reg  <= in_end_reg ? '0 : cnt_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        res_id_reg <= res_id_next;
        // registered from res_id_reg; first used at ACK byte 4
        ack_crc_reg <= crc8_update(crc8_update(AckSeed, hex_char_out(res_id_reg[7:4])),
                                   hex_char_out(res_id_reg[3:0]));
    end

    // ---------------- output mux ----------------
    always_comb
    begin
        case (out_idx_reg)
            3'd1:    out_byte = CH_A;
            3'd2:    out_byte = hex_char_out(res_id_reg[7:4]);
            3'd3:    out_byte = hex_char_out(res_id_reg[3:0]);
            3'd4:    out_byte = hex_char_out(ack_crc_reg[7:4]);
            3'd5:    out_byte = hex_char_out(ack_crc_reg[3:0]);
            3'd6:    out_byte = CH_CR;
            3'd7:    out_byte = CH_LF;
            default: out_byte = 8'h00;   // verdict transaction
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = (out_idx_reg != 3'd0);
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {6'h00, out_byte, res_id_reg, res_verdict_reg};

    // ---------------- assertions ----------------
    a_ack_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_idx_reg != 3'd0) |-> res_verdict_reg == VERD_DATA)
        else $error("ACK byte sent for a non-data verdict");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_verdict_reg == VERD_REJECT) |->
            m_axis_tlast && (res_id_reg == 8'h00))
        else $error("rejected verdict not alone or carries an id");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && in_end_reg && out_valid_reg)
        else $error("input stalled without a pending frame end");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_idx_reg))
        else $error("result transaction changed while stalled");

endmodule

`default_nettype wire
